// ===== rtl/core/lse_pkg.sv =====
// lse_pkg: shared types and constants for the LIFO stack engine.
// Used by lse_ctrl, lse_dp and lifo_stack_engine; no dependencies.
`default_nettype none

package lse_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int MAX_RESULTS     = 64;
  localparam int WORD_W          = 32;
  localparam int ACTION_W        = 3;
  localparam int STATUS_W        = 2;
  localparam int COUNT_OUT_W     = 7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PEEK   = 3'd0,
    ACT_PUSH   = 3'd1,
    ACT_POP    = 3'd2,
    ACT_EMPTYQ = 3'd3,
    ACT_DUMP   = 3'd4,
    ACT_CREATE = 3'd5,
    ACT_SIZE   = 3'd6
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOSTACK = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EMIT = 2'd1,
    S_DUMP = 2'd2
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic exec;       // execute the accepted request
    logic emit;       // load the pending single result into the output register
    logic dump_emit;  // load the current dump word, fetch the next one
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic nop;        // unused action code, no result
    logic dump_run;   // dump on a non-empty stack
    logic dump_last;  // current dump word is the final one
    logic out_free;   // output register can take a result this cycle
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/lifo_stack_engine.sv =====
// lifo_stack_engine: top level, LIFO stack of signed 32-bit words.
// A single result is held in the pending registers, then loaded into the
// output register when that is free; a new request is taken only when idle.
// A dump does one store read per word; it waits while the result side stalls.
// Reset: no stack exists and the count is zero; the entry store is not cleared.
// Depends on lse_pkg, lse_ctrl, lse_dp and lse_ram.
`default_nettype none

module lifo_stack_engine #(
  parameter int STACK_DEPTH = lse_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic        [lse_pkg::ACTION_W-1:0]    in_action,
  input  wire logic signed [lse_pkg::WORD_W-1:0]      in_push_value,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic             [lse_pkg::STATUS_W-1:0]    out_status,
  output logic signed      [lse_pkg::WORD_W-1:0]      out_data_word,
  output logic                                        out_empty_flag,
  output logic             [lse_pkg::COUNT_OUT_W-1:0] out_element_count,
  output logic                                        out_last
);

  lse_pkg::cmd_t cmd;
  lse_pkg::sts_t sts;

  lse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lse_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_action         (in_action),
    .in_push_value     (in_push_value),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_data_word     (out_data_word),
    .out_empty_flag    (out_empty_flag),
    .out_element_count (out_element_count),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire

// ===== rtl/core/lse_ram.sv =====
// lse_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lse_ctrl.sv =====
// lse_ctrl: request sequencing state machine for the LIFO stack engine.
// Depends on lse_pkg (state_t, cmd_t, sts_t).
`default_nettype none

module lse_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire lse_pkg::sts_t sts,
  output lse_pkg::cmd_t      cmd
);

  lse_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lse_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      lse_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.exec = 1'b1;
          if (sts.nop) begin
            state_nxt = lse_pkg::S_IDLE;
          end else if (sts.dump_run) begin
            state_nxt = lse_pkg::S_DUMP;
          end else begin
            state_nxt = lse_pkg::S_EMIT;
          end
        end
      end
      lse_pkg::S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = lse_pkg::S_IDLE;
        end
      end
      lse_pkg::S_DUMP: begin
        if (sts.out_free) begin
          cmd.dump_emit = 1'b1;
          if (sts.dump_last) begin
            state_nxt = lse_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = lse_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/lse_dp.sv =====
// lse_dp: stack datapath: exists flag, element count, entry store, dump
// index and output register. Depends on lse_pkg and lse_ram.
`default_nettype none

module lse_dp #(
  parameter int STACK_DEPTH = lse_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic        [lse_pkg::ACTION_W-1:0]    in_action,
  input  wire logic signed [lse_pkg::WORD_W-1:0]      in_push_value,
  input  wire lse_pkg::cmd_t                          cmd,
  output lse_pkg::sts_t                               sts,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic             [lse_pkg::STATUS_W-1:0]    out_status,
  output logic signed      [lse_pkg::WORD_W-1:0]      out_data_word,
  output logic                                        out_empty_flag,
  output logic             [lse_pkg::COUNT_OUT_W-1:0] out_element_count,
  output logic                                        out_last
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int IW  = $clog2(lse_pkg::MAX_RESULTS);
  localparam int NW  = $clog2(lse_pkg::MAX_RESULTS + 1);
  localparam int XW  = (CW > NW) ? CW : NW;
  localparam int WW  = lse_pkg::WORD_W;

  // stack state
  logic          exists_r, exists_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // pending single result
  logic [lse_pkg::STATUS_W-1:0] pend_status_r, pend_status_nxt;
  logic [WW-1:0]                pend_word_r, pend_word_nxt;
  logic                         pend_use_rd_r, pend_use_rd_nxt;

  // dump run
  logic [IW-1:0] dump_idx_r, dump_idx_nxt;
  logic [NW-1:0] dump_n_r, dump_n_nxt;
  logic [NW-1:0] dump_n_calc;
  logic          dump_last;

  // store ports
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [WW-1:0] rd_data;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic [lse_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [WW-1:0]                out_word_r, out_word_nxt;
  logic                         out_empty_r, out_empty_nxt;
  logic [lse_pkg::COUNT_OUT_W-1:0] out_count_r, out_count_nxt;
  logic                         out_last_r, out_last_nxt;

  logic out_free;
  logic is_full;
  logic is_zero;
  logic known_action;

  lse_ram #(
    .WIDTH (WW),
    .DEPTH (STACK_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_push_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign is_full     = (count_r == CW'(STACK_DEPTH));
  assign is_zero     = (count_r == '0);
  assign dump_n_calc = (XW'(count_r) > XW'(lse_pkg::MAX_RESULTS)) ?
                       NW'(lse_pkg::MAX_RESULTS) : NW'(count_r);
  assign dump_last   = ((NW'(dump_idx_r) + NW'(1)) == dump_n_r);
  assign out_free    = !out_valid_r || !out_stall;

  always_comb begin
    case (lse_pkg::action_t'(in_action))
      lse_pkg::ACT_PEEK,
      lse_pkg::ACT_PUSH,
      lse_pkg::ACT_POP,
      lse_pkg::ACT_EMPTYQ,
      lse_pkg::ACT_DUMP,
      lse_pkg::ACT_CREATE,
      lse_pkg::ACT_SIZE: known_action = 1'b1;
      default:           known_action = 1'b0;
    endcase
  end

  always_comb begin
    sts.nop       = !known_action;
    sts.dump_run  = (in_action == lse_pkg::ACT_DUMP) && exists_r && !is_zero;
    sts.dump_last = dump_last;
    sts.out_free  = out_free;
  end

  always_comb begin
    exists_nxt      = exists_r;
    count_nxt       = count_r;
    pend_status_nxt = pend_status_r;
    pend_word_nxt   = pend_word_r;
    pend_use_rd_nxt = pend_use_rd_r;
    dump_idx_nxt    = dump_idx_r;
    dump_n_nxt      = dump_n_r;
    wr_en           = 1'b0;
    wr_addr         = AW'(count_r);
    rd_en           = 1'b0;
    rd_addr         = '0;

    if (cmd.exec) begin
      pend_status_nxt = lse_pkg::ST_OK;
      pend_word_nxt   = '0;
      pend_use_rd_nxt = 1'b0;
      if (in_action == lse_pkg::ACT_CREATE) begin
        exists_nxt = 1'b1;
        count_nxt  = '0;
      end else if (!exists_r) begin
        pend_status_nxt = lse_pkg::ST_NOSTACK;
        if (in_action == lse_pkg::ACT_PEEK) begin
          pend_word_nxt = '1;
        end
      end else begin
        case (lse_pkg::action_t'(in_action))
          lse_pkg::ACT_PEEK: begin
            if (is_zero) begin
              pend_status_nxt = lse_pkg::ST_EMPTY;
              pend_word_nxt   = '1;
            end else begin
              rd_en           = 1'b1;
              rd_addr         = AW'(count_r - 1'b1);
              pend_use_rd_nxt = 1'b1;
            end
          end
          lse_pkg::ACT_PUSH: begin
            if (is_full) begin
              pend_status_nxt = lse_pkg::ST_FULL;
            end else begin
              wr_en     = 1'b1;
              count_nxt = CW'(count_r + 1'b1);
            end
          end
          lse_pkg::ACT_POP: begin
            if (is_zero) begin
              pend_status_nxt = lse_pkg::ST_EMPTY;
            end else begin
              count_nxt = CW'(count_r - 1'b1);
            end
          end
          lse_pkg::ACT_DUMP: begin
            // empty dump falls through as a single ok result
            dump_idx_nxt = '0;
            dump_n_nxt   = dump_n_calc;
            rd_en        = !is_zero;
            rd_addr      = '0;
          end
          default: begin
          end
        endcase
      end
    end

    if (cmd.dump_emit) begin
      dump_idx_nxt = IW'(dump_idx_r + 1'b1);
      rd_en        = !dump_last;
      rd_addr      = AW'(IW'(dump_idx_r + 1'b1));
    end
  end

  always_comb begin
    out_status_nxt = out_status_r;
    out_word_nxt   = out_word_r;
    out_empty_nxt  = out_empty_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && out_stall;
    if (cmd.emit || cmd.dump_emit) begin
      out_valid_nxt = 1'b1;
      out_empty_nxt = exists_r && is_zero;
      out_count_nxt = lse_pkg::COUNT_OUT_W'(count_r);
      if (cmd.emit) begin
        out_status_nxt = pend_status_r;
        out_word_nxt   = pend_use_rd_r ? rd_data : pend_word_r;
        out_last_nxt   = 1'b1;
      end else begin
        out_status_nxt = lse_pkg::ST_OK;
        out_word_nxt   = rd_data;
        out_last_nxt   = dump_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exists_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      exists_r    <= exists_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_status_r <= pend_status_nxt;
    pend_word_r   <= pend_word_nxt;
    pend_use_rd_r <= pend_use_rd_nxt;
    dump_idx_r    <= dump_idx_nxt;
    dump_n_r      <= dump_n_nxt;
    out_status_r  <= out_status_nxt;
    out_word_r    <= out_word_nxt;
    out_empty_r   <= out_empty_nxt;
    out_count_r   <= out_count_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_data_word     = out_word_r;
  assign out_empty_flag    = out_empty_r;
  assign out_element_count = out_count_r;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire
